// ===== rtl/ffla_pkg.sv =====
// ----------------------------------------------------------------------------
// ffla_pkg
// Constants and helpers shared by the fast float log approximation pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ffla_pkg;

  // range reduction constants and the canonical quiet nan
  localparam logic [31:0] LOG_OFFSET = 32'h3f2aaaab;
  localparam logic [31:0] EXP_MASK   = 32'hff800000;
  localparam logic [31:0] QNAN_BITS  = 32'h7fc00000;

  // single precision operands, raw bits
  localparam logic [31:0] ONE_BITS     = 32'h3f800000;
  localparam logic [31:0] NEG_ONE_BITS = 32'hbf800000;
  localparam logic [31:0] ZERO_BITS    = 32'h00000000;
  localparam logic [31:0] LN2_BITS     = 32'h3f317218;

  // log1p polynomial coefficients
  localparam logic [31:0] COEF4 = 32'h3e6c6078;  // 0.230836749
  localparam logic [31:0] COEF3 = 32'hbe8ef46d;  // -0.279208571
  localparam logic [31:0] COEF2 = 32'h3ea9e51a;  // 0.331826031
  localparam logic [31:0] COEF1 = 32'hbeff712d;  // -0.498910338

  // register stages in one fused multiply-add unit
  localparam int FMA_LAT = 5;
  // request accepted to result strobe, in clock edges
  localparam int LATENCY = 5 * FMA_LAT + 2;

  // small signed integer to single precision, always exact
  function automatic logic [31:0] int9_to_float(input logic signed [8:0] k);
    logic       neg;
    logic [8:0] mag;
    logic [3:0] msb;
    logic [31:0] sh;
    logic [31:0] res;
    neg = k[8];
    mag = neg ? 9'(-k) : 9'(k);
    msb = 4'd0;
    for (int i = 0; i < 9; i++) begin
      if (mag[i]) begin
        msb = 4'(i);
      end
    end
    sh = {23'b0, mag} << (5'd23 - {1'b0, msb});
    if (mag == 9'd0) begin
      res = 32'h0;
    end else begin
      res = {neg, 8'(8'd127 + {4'b0, msb}), sh[22:0]};
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ffla_fma.sv =====
// ----------------------------------------------------------------------------
// ffla_fma
// Pipelined single precision fused multiply-add, r = a*b + c, one rounding
// to nearest even, five register stages, one request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ffla_fma (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  logic [31:0] b,
  input  logic [31:0] c,
  output logic        out_valid,
  output logic [31:0] r
);

  // stage 1: unpack and multiply
  logic [7:0]  ea, eb, ec;
  logic [23:0] ma, mb, mc;

  always_comb begin
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ec = (c[30:23] == 8'd0) ? 8'd1 : c[30:23];
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    mc = {|c[30:23], c[22:0]};
  end

  logic        s1_v;
  logic [47:0] s1_prod;
  logic        s1_sp, s1_sc;
  logic [8:0]  s1_esum;
  logic [7:0]  s1_ec;
  logic [23:0] s1_mc;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else begin
      s1_v <= in_valid;
    end
    s1_prod <= ma * mb;
    s1_sp   <= a[31] ^ b[31];
    s1_sc   <= c[31];
    s1_esum <= {1'b0, ea} + {1'b0, eb};
    s1_ec   <= ec;
    s1_mc   <= mc;
  end

  // stage 2: align addend against product, far bits fold into a sticky bit
  logic signed [10:0] pos, kfull, wexp2;
  logic               pz, clamp;
  logic [4:0]         kc;
  logic [48:0]        ext;
  logic [74:0]        pw2, cw2;

  always_comb begin
    pos   = $signed({3'b0, s1_ec}) - $signed({2'b0, s1_esum}) + 11'sd151;
    kfull = 11'sd1 - pos;
    kc    = (kfull > 11'sd25) ? 5'd25 : kfull[4:0];
    ext   = {s1_mc, 25'b0} >> kc;
    pz    = (s1_prod == 48'd0);
    clamp = pz || ((pos > 11'sd51) && (s1_mc != 24'd0));
    if (clamp) begin
      // addend far above the product, or product zero: product is only sticky
      cw2   = {s1_mc, 51'b0};
      pw2   = {74'b0, !pz};
      wexp2 = $signed({3'b0, s1_ec}) - 11'sd201;
    end else begin
      pw2   = {26'b0, s1_prod, 1'b0};
      wexp2 = $signed({2'b0, s1_esum}) - 11'sd301;
      if (pos >= 11'sd1) begin
        cw2 = 75'(s1_mc) << pos[5:0];
      end else begin
        cw2 = {50'b0, ext[48:25], |ext[24:0]};
      end
    end
  end

  logic               s2_v;
  logic [74:0]        s2_pw, s2_cw;
  logic               s2_sp, s2_sc;
  logic signed [10:0] s2_wexp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else begin
      s2_v <= s1_v;
    end
    s2_pw   <= pw2;
    s2_cw   <= cw2;
    s2_sp   <= s1_sp;
    s2_sc   <= s1_sc;
    s2_wexp <= wexp2;
  end

  // stage 3: signed sum
  logic signed [76:0] pt, ct;

  always_comb begin
    pt = s2_sp ? -$signed({2'b0, s2_pw}) : $signed({2'b0, s2_pw});
    ct = s2_sc ? -$signed({2'b0, s2_cw}) : $signed({2'b0, s2_cw});
  end

  logic               s3_v;
  logic signed [76:0] s3_sum;
  logic               s3_zs;
  logic signed [10:0] s3_wexp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else begin
      s3_v <= s2_v;
    end
    s3_sum  <= pt + ct;
    s3_zs   <= s2_sp & s2_sc;
    s3_wexp <= s2_wexp;
  end

  // stage 4: magnitude and leading one
  logic [75:0] mag;
  logic [6:0]  lead;

  always_comb begin
    mag  = s3_sum[76] ? 76'(-s3_sum) : s3_sum[75:0];
    lead = 7'd0;
    for (int i = 0; i < 76; i++) begin
      if (mag[i]) begin
        lead = 7'(i);
      end
    end
  end

  logic               s4_v;
  logic [75:0]        s4_mag;
  logic [6:0]         s4_lead;
  logic               s4_neg, s4_zero, s4_zs;
  logic signed [10:0] s4_wexp;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else begin
      s4_v <= s3_v;
    end
    s4_mag  <= mag;
    s4_lead <= lead;
    s4_neg  <= s3_sum[76];
    s4_zero <= (mag == 76'd0);
    s4_zs   <= s3_zs;
    s4_wexp <= s3_wexp;
  end

  // stage 5: normalize, round to nearest even, pack
  logic [75:0]        norm;
  logic               rnd;
  logic signed [11:0] expo;
  logic [30:0]        packed_mag;

  always_comb begin
    norm = s4_mag << (7'd75 - s4_lead);
    rnd  = norm[51] & ((|norm[50:0]) | norm[52]);
    expo = 12'(s4_wexp) + $signed({5'b0, s4_lead}) + 12'sd127;
    packed_mag = {expo[7:0], norm[74:52]} + 31'(rnd);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= s4_v;
    end
    r <= s4_zero ? {s4_zs, 31'b0} : {s4_neg, packed_mag};
  end

endmodule

`default_nettype wire

// ===== rtl/fast_float_log_approx.sv =====
// throughput: one request per cycle, busy stays low, results are never held off
// the depth is seven fused multiply-add units of five stages, five of them in series
// reset: clears every valid bit in the pipeline, payload registers are not reset
// ----------------------------------------------------------------------------
// fast_float_log_approx
// Approximate natural log of a single precision value, bits in and bits out:
// exponent split by integer subtraction, degree-5 polynomial in f = m - 1.
// ----------------------------------------------------------------------------
`default_nettype none

module fast_float_log_approx (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_bits,
  output logic        done,
  output logic [31:0] log_bits
);

  localparam int F = ffla_pkg::FMA_LAT;

  // the pipeline takes a request every cycle
  assign busy = 1'b0;

  // input stage: range reduction
  // diff upper nine bits are the signed exponent k, mantissa lands in [2/3, 4/3]
  logic [31:0] diff, ebits;

  always_comb begin
    diff  = value_bits - ffla_pkg::LOG_OFFSET;
    ebits = diff & ffla_pkg::EXP_MASK;
  end

  logic        in_v;
  logic [31:0] mant_bits;
  logic [31:0] ef_bits;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_v <= 1'b0;
    end else begin
      in_v <= start && !busy;
    end
    mant_bits <= value_bits - ebits;
    // k * 2^23 scaled by 2^-23 is just k
    ef_bits   <= ffla_pkg::int9_to_float($signed(diff[31:23]));
  end

  // f = m - 1, exact
  logic        frac_v;
  logic [31:0] frac;

  ffla_fma u_frac (
    .clk(clk), .rst(rst), .in_valid(in_v),
    .a(mant_bits), .b(ffla_pkg::ONE_BITS), .c(ffla_pkg::NEG_ONE_BITS),
    .out_valid(frac_v), .r(frac)
  );

  // second level: f squared and the two first-order terms side by side
  logic        sq_v, p_v, q_v;
  logic [31:0] sq, p1, q1;

  ffla_fma u_sq (
    .clk(clk), .rst(rst), .in_valid(frac_v),
    .a(frac), .b(frac), .c(ffla_pkg::ZERO_BITS),
    .out_valid(sq_v), .r(sq)
  );

  ffla_fma u_p (
    .clk(clk), .rst(rst), .in_valid(frac_v),
    .a(ffla_pkg::COEF4), .b(frac), .c(ffla_pkg::COEF3),
    .out_valid(p_v), .r(p1)
  );

  ffla_fma u_q (
    .clk(clk), .rst(rst), .in_valid(frac_v),
    .a(ffla_pkg::COEF2), .b(frac), .c(ffla_pkg::COEF1),
    .out_valid(q_v), .r(q1)
  );

  // side delay lines that keep f, f squared and k in step with the chain
  logic [31:0] ef_line   [4*F];
  logic [31:0] frac_line [2*F];
  logic [31:0] sq_line   [F];

  always_ff @(posedge clk) begin
    ef_line[0]   <= ef_bits;
    frac_line[0] <= frac;
    sq_line[0]   <= sq;
    for (int i = 1; i < 4*F; i++) begin
      ef_line[i] <= ef_line[i-1];
    end
    for (int i = 1; i < 2*F; i++) begin
      frac_line[i] <= frac_line[i-1];
    end
    for (int i = 1; i < F; i++) begin
      sq_line[i] <= sq_line[i-1];
    end
  end

  // p = p * f^2 + q
  logic        p2_v;
  logic [31:0] p2;

  ffla_fma u_p2 (
    .clk(clk), .rst(rst), .in_valid(sq_v & p_v & q_v),
    .a(p1), .b(sq), .c(q1),
    .out_valid(p2_v), .r(p2)
  );

  // p = p * f^2 + f
  logic        p3_v;
  logic [31:0] p3;

  ffla_fma u_p3 (
    .clk(clk), .rst(rst), .in_valid(p2_v),
    .a(p2), .b(sq_line[F-1]), .c(frac_line[2*F-1]),
    .out_valid(p3_v), .r(p3)
  );

  // k * log(2) + p
  logic        acc_v;
  logic [31:0] acc;

  ffla_fma u_acc (
    .clk(clk), .rst(rst), .in_valid(p3_v),
    .a(ef_line[4*F-1]), .b(ffla_pkg::LN2_BITS), .c(p3),
    .out_valid(acc_v), .r(acc)
  );

  // output register, any nan comes out as the canonical quiet nan
  logic is_nan;

  always_comb begin
    is_nan = (acc[30:23] == 8'hff) && (acc[22:0] != 23'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= acc_v;
    end
    log_bits <= is_nan ? ffla_pkg::QNAN_BITS : acc;
  end

endmodule

`default_nettype wire

// ===== rtl/ffla_checker.sv =====
// ----------------------------------------------------------------------------
// ffla_checker
// Port-level checks on request to result timing and result encoding.
// ----------------------------------------------------------------------------
`default_nettype none

module ffla_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic [31:0] value_bits,
  input logic        done,
  input logic [31:0] log_bits
);

  // every request gets its result after the fixed latency
  a_req_to_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(ffla_pkg::LATENCY) done)
    else $error("request without result strobe");

  // no strobe without a matching request
  a_done_has_req: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, ffla_pkg::LATENCY))
    else $error("result strobe without request");

  // log of one is positive zero
  a_log_one: assert property (@(posedge clk) disable iff (rst)
    (done && $past(value_bits, ffla_pkg::LATENCY) == 32'h3f800000)
      |-> (log_bits == 32'h0))
    else $error("log of one is not zero");

  // only the canonical nan may appear
  a_nan_form: assert property (@(posedge clk) disable iff (rst)
    done |-> (!(log_bits[30:23] == 8'hff && log_bits[22:0] != 23'd0)
              || log_bits == 32'h7fc00000))
    else $error("non canonical nan");

endmodule

bind fast_float_log_approx ffla_checker u_ffla_checker (
  .clk(clk),
  .rst(rst),
  .start(start),
  .busy(busy),
  .value_bits(value_bits),
  .done(done),
  .log_bits(log_bits)
);

`default_nettype wire
